/* sv/dtt_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the deadline timer table
// no dependencies

package dtt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MAX_RES    = 16;
    localparam int CNT_W      = $clog2(MAX_RES + 1);
    localparam int GEN_W      = 32;
    localparam int NOW_W      = 63;
    localparam int VAL_W      = 64;

    typedef enum logic [1:0] {
        K_TICK   = 2'd0,
        K_ARM    = 2'd1,
        K_CANCEL = 2'd2,
        K_UPTIME = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_OK       = 3'd0,
        S_BADTOKEN = 3'd1,
        S_NOTOWNER = 3'd2,
        S_FULL     = 3'd3,
        S_NOCAP    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REPLY,
        ST_ARM_WR,
        ST_CAN_CHK,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [VAL_W-1:0] deadline;
        logic [VAL_W-1:0] bits;
        logic [VAL_W-1:0] owner;
        logic [GEN_W-1:0] gen;
    } t_entry;

endpackage

/* sv/deadline_timer_table_top.sv */
`timescale 1ns / 1ps
// deadline timer table: one-shot timers held in a single slot memory
// depends on dtt_pkg

// Usage
//   Input channel (i_in_valid / o_in_ready) carries one request: tick, arm,
//   cancel or uptime query, together with the current time. Output channel
//   (o_out_valid / i_out_ready) returns replies and fire results; o_last
//   marks the final result caused by a request.
//   One request is handled at a time; o_in_ready is high only when idle.
//   Uptime: the reply is registered, then loaded from ST_REPLY. Arm and
//   cancel: one read-modify-write of the slot memory (ST_ARM_WR or
//   ST_CAN_CHK), reply then loaded from ST_REPLY. Tick: the slot memory is
//   swept one slot per cycle, but a hit waits while the output register is
//   full and a fire is held; ST_FLUSH then sends the held fire, if any.
//   Each due slot is freed and its generation bumped.
//   A found fire is held until the next hit so the final one carries o_last.
//   A tick with nothing due gives no result.
//   The output register frees the input side: a new request is accepted
//   while a result still waits. When the receiver stalls, a hit that must
//   push out a held fire waits until the output register drains.
//   Reset (synchronous, active low) frees every slot and zeroes all
//   generations at once through per-slot flags; no clearing pass is needed.

module deadline_timer_table_top
    import dtt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [1:0]       i_kind,
    input  logic [NOW_W-1:0] i_now_ns,
    input  logic [VAL_W-1:0] i_duration_ns,
    input  logic [VAL_W-1:0] i_signal_bits,
    input  logic [VAL_W-1:0] i_sender_badge,
    input  logic             i_cap_present,
    input  logic [VAL_W-1:0] i_cancel_token,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_result_kind,
    output logic [2:0]       o_status,
    output logic [VAL_W-1:0] o_reply_value,
    output logic [3:0]       o_fired_slot,
    output logic [VAL_W-1:0] o_fired_bits,
    output logic             o_last
);

    // slot memory
    t_entry r_mem [NUM_TIMERS];
    t_entry r_rd;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    t_entry            mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    // control state
    t_state r_state, n_state;
    logic [NUM_TIMERS-1:0] r_used, n_used;
    logic [NUM_TIMERS-1:0] r_gen_vld, n_gen_vld;
    logic [SLOT_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_hold_vld, n_hold_vld;
    logic [SLOT_W-1:0]     r_hold_slot, n_hold_slot;
    logic [VAL_W-1:0]      r_hold_bits, n_hold_bits;

    // latched request
    logic [NOW_W-1:0] r_now;
    logic [VAL_W-1:0] r_dur;
    logic [VAL_W-1:0] r_sig;
    logic [VAL_W-1:0] r_badge;
    logic [VAL_W-1:0] r_tok;
    t_status          r_status, n_status;
    logic [VAL_W-1:0] r_reply, n_reply;

    // output register
    logic             r_out_valid;
    logic             r_o_kind;
    logic [2:0]       r_o_status;
    logic [VAL_W-1:0] r_o_reply;
    logic [3:0]       r_o_slot;
    logic [VAL_W-1:0] r_o_bits;
    logic             r_o_last;

    logic             emit;
    logic             e_kind;
    t_status          e_status;
    logic [VAL_W-1:0] e_reply;
    logic [SLOT_W-1:0] e_slot;
    logic [VAL_W-1:0] e_bits;
    logic             e_last;

    logic              accept;
    logic              out_free;
    logic              any_free;
    logic [SLOT_W-1:0] free_slot;
    logic [31:0]       tok_k1;
    logic [31:0]       tok_k;
    logic [GEN_W-1:0]  gen_eff;
    logic              hit;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign tok_k1     = i_cancel_token[31:0];
    assign tok_k      = tok_k1 - 32'd1;
    assign gen_eff    = r_gen_vld[r_idx] ? r_rd.gen : '0;
    assign hit        = r_used[r_idx] && !({1'b0, r_now} < r_rd.deadline)
                        && (r_cnt < CNT_W'(MAX_RES));

    // lowest free slot
    always_comb begin
        any_free  = 1'b0;
        free_slot = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                any_free  = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_gen_vld   = r_gen_vld;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_hold_vld  = r_hold_vld;
        n_hold_slot = r_hold_slot;
        n_hold_bits = r_hold_bits;
        n_status    = r_status;
        n_reply     = r_reply;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_rd;
        emit        = 1'b0;
        e_kind      = 1'b0;
        e_status    = r_status;
        e_reply     = r_reply;
        e_slot      = '0;
        e_bits      = '0;
        e_last      = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_status = S_OK;
                    n_reply  = '0;
                    case (t_kind'(i_kind))
                        K_TICK: begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            n_idx      = '0;
                            n_cnt      = '0;
                            n_hold_vld = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        K_ARM: begin
                            if (!any_free) begin
                                n_status = S_FULL;
                                n_state  = ST_REPLY;
                            end else if (!i_cap_present) begin
                                n_status = S_NOCAP;
                                n_state  = ST_REPLY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = free_slot;
                                n_idx     = free_slot;
                                n_state   = ST_ARM_WR;
                            end
                        end
                        K_CANCEL: begin
                            if (tok_k1 == 32'd0 || tok_k1 > 32'(NUM_TIMERS)) begin
                                n_status = S_BADTOKEN;
                                n_state  = ST_REPLY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = tok_k[SLOT_W-1:0];
                                n_idx     = tok_k[SLOT_W-1:0];
                                n_state   = ST_CAN_CHK;
                            end
                        end
                        default: begin
                            n_reply = {1'b0, i_now_ns};
                            n_state = ST_REPLY;
                        end
                    endcase
                end
            end
            ST_ARM_WR: begin
                mem_we             = 1'b1;
                mem_wdata.deadline = {1'b0, r_now} + r_dur;
                mem_wdata.bits     = (r_sig == '0) ? VAL_W'(1) : r_sig;
                mem_wdata.owner    = r_badge;
                mem_wdata.gen      = gen_eff;
                n_used[r_idx]      = 1'b1;
                n_gen_vld[r_idx]   = 1'b1;
                n_reply            = {gen_eff, 32'(r_idx) + 32'd1};
                n_state            = ST_REPLY;
            end
            ST_CAN_CHK: begin
                if (!r_used[r_idx] || gen_eff != r_tok[63:32]) begin
                    n_status = S_BADTOKEN;
                end else if (r_rd.owner != r_badge) begin
                    n_status = S_NOTOWNER;
                end else begin
                    mem_we           = 1'b1;
                    mem_wdata.gen    = gen_eff + GEN_W'(1);
                    n_used[r_idx]    = 1'b0;
                    n_gen_vld[r_idx] = 1'b1;
                end
                n_state = ST_REPLY;
            end
            ST_REPLY: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // a new hit pushes the held fire out first
                if (!(hit && r_hold_vld && !out_free)) begin
                    if (hit) begin
                        if (r_hold_vld) begin
                            emit     = 1'b1;
                            e_kind   = 1'b1;
                            e_status = S_OK;
                            e_reply  = '0;
                            e_slot   = r_hold_slot;
                            e_bits   = r_hold_bits;
                            e_last   = 1'b0;
                        end
                        n_hold_vld       = 1'b1;
                        n_hold_slot      = r_idx;
                        n_hold_bits      = r_rd.bits;
                        mem_we           = 1'b1;
                        mem_wdata.gen    = gen_eff + GEN_W'(1);
                        n_used[r_idx]    = 1'b0;
                        n_gen_vld[r_idx] = 1'b1;
                        n_cnt            = r_cnt + CNT_W'(1);
                    end
                    if (r_idx == SLOT_W'(NUM_TIMERS - 1)) begin
                        n_state = ST_FLUSH;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_idx + SLOT_W'(1);
                        n_idx     = r_idx + SLOT_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_hold_vld) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    emit       = 1'b1;
                    e_kind     = 1'b1;
                    e_status   = S_OK;
                    e_reply    = '0;
                    e_slot     = r_hold_slot;
                    e_bits     = r_hold_bits;
                    e_last     = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_gen_vld   <= '0;
            r_hold_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_gen_vld   <= n_gen_vld;
            r_hold_vld  <= n_hold_vld;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_cnt       <= n_cnt;
        r_hold_slot <= n_hold_slot;
        r_hold_bits <= n_hold_bits;
        r_status    <= n_status;
        r_reply     <= n_reply;
        if (accept) begin
            r_now   <= i_now_ns;
            r_dur   <= i_duration_ns;
            r_sig   <= i_signal_bits;
            r_badge <= i_sender_badge;
            r_tok   <= i_cancel_token;
        end
        if (emit) begin
            r_o_kind   <= e_kind;
            r_o_status <= e_status;
            r_o_reply  <= e_reply;
            r_o_slot   <= 4'(e_slot);
            r_o_bits   <= e_bits;
            r_o_last   <= e_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_o_kind;
    assign o_status      = r_o_status;
    assign o_reply_value = r_o_reply;
    assign o_fired_slot  = r_o_slot;
    assign o_fired_bits  = r_o_bits;
    assign o_last        = r_o_last;

endmodule

/* bench/deadline_timer_table_top_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for deadline_timer_table_top: directed and random requests,
// every result checked against a slot-table predictor held in a scoreboard class
// depends on dtt_pkg and the deadline timer table rtl

module deadline_timer_table_top_tb;

    import dtt_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 360;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};

    typedef struct packed {
        logic             result_kind;
        logic [2:0]       status;
        logic [VAL_W-1:0] reply_value;
        logic [3:0]       fired_slot;
        logic [VAL_W-1:0] fired_bits;
        logic             last;
    } timer_result_t;

    class timer_table_sb;
        bit               slot_used  [NUM_TIMERS];
        logic [GEN_W-1:0] slot_gen   [NUM_TIMERS];
        logic [VAL_W-1:0] slot_due   [NUM_TIMERS];
        logic [VAL_W-1:0] slot_bits  [NUM_TIMERS];
        logic [VAL_W-1:0] slot_owner [NUM_TIMERS];
        timer_result_t    pending_results[$];
        int               errors;
        int               reported;

        function new();
            for (int i = 0; i < NUM_TIMERS; i++) begin
                slot_used[i]  = 1'b0;
                slot_gen[i]   = '0;
                slot_due[i]   = '0;
                slot_bits[i]  = '0;
                slot_owner[i] = '0;
            end
        endfunction

        function void add(logic rk, logic [2:0] st, logic [VAL_W-1:0] rv, logic [3:0] fs,
                          logic [VAL_W-1:0] fb, logic last);
            pending_results.push_back(timer_result_t'({rk, st, rv, fs, fb, last}));
        endfunction

        function void note_request(t_kind kind, logic [NOW_W-1:0] now_ns,
                                   logic [VAL_W-1:0] dur, logic [VAL_W-1:0] sig,
                                   logic [VAL_W-1:0] badge, logic cap,
                                   logic [VAL_W-1:0] tok);
            logic [VAL_W-1:0] now64;
            logic [31:0]      slot_plus1;
            int               due_cnt;
            int               n;
            int               free_slot;
            now64 = {1'b0, now_ns};
            case (kind)
                K_TICK: begin
                    due_cnt = 0;
                    for (int i = 0; i < NUM_TIMERS; i++)
                        if (slot_used[i] && now64 >= slot_due[i] && due_cnt < MAX_RES)
                            due_cnt++;
                    // fires go out in slot order, the final one marked last
                    n = 0;
                    for (int i = 0; i < NUM_TIMERS && n < due_cnt; i++) begin
                        if (slot_used[i] && now64 >= slot_due[i]) begin
                            n++;
                            add(1'b1, S_OK, '0, 4'(i), slot_bits[i], n == due_cnt);
                            slot_used[i] = 1'b0;
                            slot_gen[i]  = slot_gen[i] + 1'b1;
                        end
                    end
                end
                K_ARM: begin
                    free_slot = -1;
                    for (int i = NUM_TIMERS - 1; i >= 0; i--)
                        if (!slot_used[i])
                            free_slot = i;
                    if (free_slot < 0) begin
                        add(1'b0, S_FULL, '0, '0, '0, 1'b1);
                    end else if (!cap) begin
                        add(1'b0, S_NOCAP, '0, '0, '0, 1'b1);
                    end else begin
                        slot_due[free_slot]   = now64 + dur;
                        slot_bits[free_slot]  = (sig == '0) ? 64'd1 : sig;
                        slot_owner[free_slot] = badge;
                        slot_used[free_slot]  = 1'b1;
                        add(1'b0, S_OK, {slot_gen[free_slot], 32'(free_slot + 1)},
                            '0, '0, 1'b1);
                    end
                end
                K_CANCEL: begin
                    slot_plus1 = tok[31:0];
                    if (slot_plus1 == 0 || slot_plus1 > NUM_TIMERS) begin
                        add(1'b0, S_BADTOKEN, '0, '0, '0, 1'b1);
                    end else begin
                        n = slot_plus1 - 1;
                        if (!slot_used[n] || slot_gen[n] != tok[63:32]) begin
                            add(1'b0, S_BADTOKEN, '0, '0, '0, 1'b1);
                        end else if (slot_owner[n] != badge) begin
                            add(1'b0, S_NOTOWNER, '0, '0, '0, 1'b1);
                        end else begin
                            slot_used[n] = 1'b0;
                            slot_gen[n]  = slot_gen[n] + 1'b1;
                            add(1'b0, S_OK, '0, '0, '0, 1'b1);
                        end
                    end
                end
                K_UPTIME: begin
                    add(1'b0, S_OK, now64, '0, '0, 1'b1);
                end
            endcase
        endfunction

        function string describe(timer_result_t r);
            return $sformatf("kind %0d status %0d value %h slot %0d bits %h last %0d",
                             r.result_kind, r.status, r.reply_value, r.fired_slot,
                             r.fired_bits, r.last);
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result: %s", describe(got));
                end
                return;
            end
            want = pending_results.pop_front();
            if (got !== want) begin
                errors++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch: expected %s", describe(want));
                    $display("          actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_in_valid     = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_kind         = '0;
    logic [NOW_W-1:0] i_now_ns       = '0;
    logic [VAL_W-1:0] i_duration_ns  = '0;
    logic [VAL_W-1:0] i_signal_bits  = '0;
    logic [VAL_W-1:0] i_sender_badge = '0;
    logic             i_cap_present  = 1'b0;
    logic [VAL_W-1:0] i_cancel_token = '0;
    logic             o_out_valid;
    logic             i_out_ready    = 1'b0;
    logic             o_result_kind;
    logic [2:0]       o_status;
    logic [VAL_W-1:0] o_reply_value;
    logic [3:0]       o_fired_slot;
    logic [VAL_W-1:0] o_fired_bits;
    logic             o_last;

    timer_table_sb sb = new();
    int gap_pct   = 13;
    int stall_pct = 13;
    int quiet_cycles = 0;

    deadline_timer_table_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_now_ns       (i_now_ns),
        .i_duration_ns  (i_duration_ns),
        .i_signal_bits  (i_signal_bits),
        .i_sender_badge (i_sender_badge),
        .i_cap_present  (i_cap_present),
        .i_cancel_token (i_cancel_token),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_status       (o_status),
        .o_reply_value  (o_reply_value),
        .o_fired_slot   (o_fired_slot),
        .o_fired_bits   (o_fired_bits),
        .o_last         (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // results are checked before the request of the same edge is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(timer_result_t'({o_result_kind, o_status, o_reply_value,
                                                 o_fired_slot, o_fired_bits, o_last}));
            if (i_in_valid && o_in_ready)
                sb.note_request(t_kind'(i_kind), i_now_ns, i_duration_ns, i_signal_bits,
                                i_sender_badge, i_cap_present, i_cancel_token);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input t_kind kind, input logic [NOW_W-1:0] now_ns,
                                input logic [VAL_W-1:0] dur, input logic [VAL_W-1:0] sig,
                                input logic [VAL_W-1:0] badge, input logic cap,
                                input logic [VAL_W-1:0] tok);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_now_ns       <= now_ns;
        i_duration_ns  <= dur;
        i_signal_bits  <= sig;
        i_sender_badge <= badge;
        i_cap_present  <= cap;
        i_cancel_token <= tok;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    initial begin
        int               r;
        int               slot;
        int               dur_max;
        logic [NOW_W-1:0] sim_now;
        logic [VAL_W-1:0] dur;
        logic [VAL_W-1:0] sig;
        logic [VAL_W-1:0] badge;
        logic [VAL_W-1:0] tok;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(K_UPTIME, NOW_MAX, '0, '0, '0, 1'b0, '0);
        // empty table, nothing due, no result
        send_request(K_TICK, '0, '0, '0, '0, 1'b0, '0);
        send_request(K_CANCEL, 63'd5, '0, '0, '0, 1'b0, '0);
        send_request(K_CANCEL, 63'd5, '0, '0, '0, 1'b0, {32'd0, 32'(NUM_TIMERS + 1)});
        send_request(K_ARM, 63'd1000, 64'd10, 64'd3, 64'd7, 1'b0, '0);
        for (int i = 0; i < NUM_TIMERS; i++) begin
            sig = rand64();
            if (i == 0) begin
                dur = '0;
                sig = '0;
            end else if (i == 1) begin
                dur = '1;   // deadline wraps to just below now
            end else begin
                dur = 64'(i * 10);
            end
            send_request(K_ARM, 63'd1000, dur, sig, 64'(i), 1'b1, '0);
        end
        send_request(K_ARM, 63'd1100, 64'd5, '1, 64'd99, 1'b1, '0);
        // full table wins over missing capability
        send_request(K_ARM, 63'd1100, 64'd5, '1, 64'd99, 1'b0, '0);
        send_request(K_CANCEL, 63'd1100, '0, '0, 64'd99, 1'b0, {32'd0, 32'd3});
        send_request(K_CANCEL, 63'd1100, '0, '0, 64'd2, 1'b0, {32'd0, 32'd3});
        send_request(K_ARM, 63'd1100, 64'd1, '1, 64'd2, 1'b1, '0);
        // every slot due at once
        send_request(K_TICK, NOW_MAX, '0, '0, '0, 1'b0, '0);
        send_request(K_CANCEL, 63'd1200, '0, '0, 64'd2, 1'b0, {32'd1, 32'd3});
        wait_drained();

        sim_now = 63'd5000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gap_pct   = (n >= 100 && n < 200) ? 0 : 13;
            stall_pct = gap_pct;
            dur_max   = (n >= 250 && n < 300) ? 50000 : 3000;
            if ($urandom_range(99) < 3)
                sim_now = NOW_W'(rand64());
            else
                sim_now = sim_now + NOW_W'($urandom_range(400));
            if ($urandom_range(39) == 0)
                wait_drained();
            badge = ($urandom_range(9) == 0) ? rand64() : 64'($urandom_range(3));
            r = $urandom_range(99);
            if (r < 32) begin
                dur = ($urandom_range(19) == 0) ? rand64() : 64'($urandom_range(dur_max));
                sig = ($urandom_range(7) == 0) ? '0 : rand64();
                send_request(K_ARM, sim_now, dur, sig, badge, 1'($urandom_range(9) != 0),
                             rand64());
            end else if (r < 55) begin
                send_request(K_TICK, sim_now, rand64(), rand64(), rand64(),
                             1'($urandom_range(1)), rand64());
            end else if (r < 82) begin
                slot = $urandom_range(NUM_TIMERS - 1);
                for (int k = 0; k < NUM_TIMERS; k++)
                    if (!sb.slot_used[slot])
                        slot = (slot + 1) % NUM_TIMERS;
                r = $urandom_range(9);
                if (r < 6) begin
                    tok = {sb.slot_gen[slot], 32'(slot + 1)};
                    if (r < 5)
                        badge = sb.slot_owner[slot];
                end else if (r < 8) begin
                    tok = {sb.slot_gen[slot] - 32'd1, 32'(slot + 1)};
                end else if (r == 8) begin
                    tok = {$urandom, 32'($urandom_range(NUM_TIMERS + 2))};
                end else begin
                    tok = rand64();
                end
                send_request(K_CANCEL, sim_now, rand64(), rand64(), badge,
                             1'($urandom_range(1)), tok);
            end else begin
                send_request(K_UPTIME, sim_now, rand64(), rand64(), rand64(),
                             1'($urandom_range(1)), rand64());
            end
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
        repeat (4 * NUM_TIMERS) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
